FILE: rtl/gnpl_pkg.sv
`default_nettype none
package gnpl_pkg;

    localparam int unsigned COORD_W = 24;
    localparam int unsigned LABEL_W = 16;
    localparam int unsigned GRID_W  = 16;
    localparam int unsigned DIST_W  = 25;
    localparam int unsigned SQ_W    = 50;
    localparam int unsigned CFG_W   = 25;
    localparam int unsigned IDX_W   = 1;

    localparam logic [IDX_W-1:0] REG_GRID_SIZE      = 1'd0;
    localparam logic [IDX_W-1:0] REG_QUERY_DISTANCE = 1'd1;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef struct packed {
        logic                cmd;
        logic [COORD_W-1:0]  coord_north;
        logic [COORD_W-1:0]  coord_east;
        logic [LABEL_W-1:0]  label_index;
    } t_in_item;

    typedef struct packed {
        logic                found;
        logic [LABEL_W-1:0]  nearest_label;
        logic [DIST_W-1:0]   nearest_distance;
    } t_out_item;

    typedef struct packed {
        logic                cmd;
        logic [COORD_W-1:0]  north;
        logic [COORD_W-1:0]  east;
        logic [LABEL_W-1:0]  label;
        logic [COORD_W-1:0]  cell_n;
        logic [COORD_W-1:0]  cell_e;
    } t_job;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_READ,
        B_WAIT,
        B_SQR,
        B_ROOT,
        B_DONE
    } t_back_state;

endpackage
`default_nettype wire

FILE: rtl/gnpl_front.sv
`default_nettype none
module gnpl_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire gnpl_pkg::t_in_item         i_item,
    input  wire logic [gnpl_pkg::GRID_W-1:0] i_grid,
    input  wire logic                       i_q_full,
    output logic                            o_busy,
    output logic                            o_push,
    output gnpl_pkg::t_job                  o_job
);

    // Two restoring dividers run side by side, one quotient bit a cycle.
    localparam int unsigned CW = gnpl_pkg::COORD_W;
    localparam int unsigned RW = gnpl_pkg::GRID_W + 1;

    gnpl_pkg::t_front_state r_state, n_state;
    gnpl_pkg::t_in_item     r_item;
    logic [gnpl_pkg::GRID_W-1:0] r_div;
    logic [CW-1:0] r_qn, r_qe;
    logic [RW-1:0] r_rn, r_re;
    logic [4:0]    r_cnt;
    logic [RW-1:0] w_tn, w_te;
    logic          w_sub_n, w_sub_e;

    always_comb begin
        w_tn    = {r_rn[RW-2:0], r_qn[CW-1]};
        w_te    = {r_re[RW-2:0], r_qe[CW-1]};
        w_sub_n = w_tn >= {1'b0, r_div};
        w_sub_e = w_te >= {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gnpl_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == gnpl_pkg::F_IDLE && i_start) begin
            r_item <= i_item;
            r_div  <= (i_grid == '0) ? gnpl_pkg::GRID_W'(1) : i_grid;
            r_qn   <= i_item.coord_north;
            r_qe   <= i_item.coord_east;
            r_rn   <= '0;
            r_re   <= '0;
            r_cnt  <= '0;
        end else if (r_state == gnpl_pkg::F_DIV) begin
            r_rn  <= w_sub_n ? w_tn - {1'b0, r_div} : w_tn;
            r_re  <= w_sub_e ? w_te - {1'b0, r_div} : w_te;
            r_qn  <= {r_qn[CW-2:0], w_sub_n};
            r_qe  <= {r_qe[CW-2:0], w_sub_e};
            r_cnt <= r_cnt + 5'd1;
        end
    end

    always_comb begin
        n_state = r_state;
        o_busy  = r_state != gnpl_pkg::F_IDLE;
        o_push  = 1'b0;
        case (r_state)
            gnpl_pkg::F_IDLE: if (i_start) n_state = gnpl_pkg::F_DIV;
            gnpl_pkg::F_DIV:  if (r_cnt == 5'(CW - 1)) n_state = gnpl_pkg::F_PUSH;
            gnpl_pkg::F_PUSH: begin
                if (!i_q_full) begin
                    o_push  = 1'b1;
                    n_state = gnpl_pkg::F_IDLE;
                end
            end
            default: n_state = gnpl_pkg::F_IDLE;
        endcase
    end

    assign o_job = '{cmd: r_item.cmd, north: r_item.coord_north, east: r_item.coord_east,
                     label: r_item.label_index, cell_n: r_qn, cell_e: r_qe};

endmodule
`default_nettype wire

FILE: rtl/gnpl_queue.sv
`default_nettype none
module gnpl_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire gnpl_pkg::t_job i_job,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_empty,
    output gnpl_pkg::t_job      o_job
);

    gnpl_pkg::t_job r_mem [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_job   = r_mem[r_rp];

endmodule
`default_nettype wire

FILE: rtl/gnpl_back.sv
`default_nettype none
module gnpl_back #(
    parameter int unsigned MAX_POINTS = 4096,
    parameter int unsigned PTR_W      = 12,
    parameter int unsigned CNT_W      = 13
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_empty,
    input  wire gnpl_pkg::t_job              i_job,
    input  wire logic [gnpl_pkg::DIST_W-1:0] i_qdist,
    output logic                             o_pop,
    output logic                             o_valid,
    output gnpl_pkg::t_out_item              o_result,
    output logic [CNT_W-1:0]                 o_count
);

    localparam int unsigned CW = gnpl_pkg::COORD_W;
    localparam int unsigned SW = gnpl_pkg::SQ_W;
    localparam int unsigned DW = gnpl_pkg::DIST_W;
    localparam int unsigned LW = gnpl_pkg::LABEL_W;

    gnpl_pkg::t_back_state r_state, n_state;
    gnpl_pkg::t_job        r_job;
    logic [2*CW+LW-1:0]    r_pmem [MAX_POINTS];
    logic [2*CW-1:0]       r_cmem [MAX_POINTS];
    logic [2*CW+LW-1:0]    r_prd;
    logic [2*CW-1:0]       r_crd;
    logic [CNT_W-1:0]      r_count, r_idx;
    logic [CW-1:0]         r_dx, r_dy;
    logic [SW-1:0]         r_sq, r_rem;
    logic [DW-1:0]         r_root, r_best;
    logic [LW-1:0]         r_lab, r_best_lab;
    logic [4:0]            r_step;
    logic                  r_any;

    logic [CW-1:0] w_pn, w_pe, w_cn, w_ce;
    logic          w_member, w_last;
    logic [SW+1:0] w_trial, w_rem2;
    logic          w_ge;

    always_comb begin
        w_pn = r_prd[2*CW+LW-1 -: CW];
        w_pe = r_prd[CW+LW-1 -: CW];
        w_cn = r_crd[2*CW-1 -: CW];
        w_ce = r_crd[CW-1:0];
        w_member = (w_cn == r_job.cell_n ||
                    {1'b0, w_cn} + (CW+1)'(1) == {1'b0, r_job.cell_n}) &&
                   (w_ce == r_job.cell_e ||
                    {1'b0, w_ce} + (CW+1)'(1) == {1'b0, r_job.cell_e});
        w_last  = r_idx + CNT_W'(1) >= r_count;
        w_rem2  = {r_rem, r_sq[SW-1 -: 2]};
        w_trial = {(SW+2-DW-2)'(0), r_root, 2'b01};
        w_ge    = w_rem2 >= w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gnpl_pkg::B_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == gnpl_pkg::B_IDLE && !i_empty &&
                i_job.cmd == gnpl_pkg::CMD_INSERT && r_count < CNT_W'(MAX_POINTS)) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == gnpl_pkg::B_IDLE && !i_empty &&
            i_job.cmd == gnpl_pkg::CMD_INSERT && r_count < CNT_W'(MAX_POINTS)) begin
            r_pmem[r_count[PTR_W-1:0]] <= {i_job.north, i_job.east, i_job.label};
            r_cmem[r_count[PTR_W-1:0]] <= {i_job.cell_n, i_job.cell_e};
        end
        r_prd <= r_pmem[r_idx[PTR_W-1:0]];
        r_crd <= r_cmem[r_idx[PTR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            gnpl_pkg::B_IDLE: begin
                r_job      <= i_job;
                r_idx      <= '0;
                r_any      <= 1'b0;
                r_best     <= '1;
                r_best_lab <= '0;
            end
            gnpl_pkg::B_WAIT: begin
                r_dx   <= (w_pn >= r_job.north) ? w_pn - r_job.north : r_job.north - w_pn;
                r_dy   <= (w_pe >= r_job.east) ? w_pe - r_job.east : r_job.east - w_pe;
                r_lab  <= r_prd[LW-1:0];
            end
            gnpl_pkg::B_SQR: begin
                r_sq   <= SW'(r_dx * r_dx) + SW'(r_dy * r_dy);
                r_rem  <= '0;
                r_root <= '0;
                r_step <= '0;
            end
            gnpl_pkg::B_ROOT: begin
                r_sq   <= {r_sq[SW-3:0], 2'b00};
                r_rem  <= w_ge ? SW'(w_rem2 - w_trial) : SW'(w_rem2);
                r_root <= {r_root[DW-2:0], w_ge};
                r_step <= r_step + 5'd1;
                if (r_step == 5'(DW - 1)) begin
                    if (!r_any || {r_root[DW-2:0], w_ge} < r_best) begin
                        r_any      <= 1'b1;
                        r_best     <= {r_root[DW-2:0], w_ge};
                        r_best_lab <= r_lab;
                    end
                    r_idx <= r_idx + CNT_W'(1);
                end
            end
            default: ;
        endcase
        if (r_state == gnpl_pkg::B_WAIT && !w_member) r_idx <= r_idx + CNT_W'(1);
    end

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        o_valid = 1'b0;
        case (r_state)
            gnpl_pkg::B_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    if (i_job.cmd == gnpl_pkg::CMD_QUERY) begin
                        n_state = (r_count == '0) ? gnpl_pkg::B_DONE : gnpl_pkg::B_READ;
                    end
                end
            end
            gnpl_pkg::B_READ: n_state = gnpl_pkg::B_WAIT;
            gnpl_pkg::B_WAIT: begin
                if (w_member) n_state = gnpl_pkg::B_SQR;
                else n_state = w_last ? gnpl_pkg::B_DONE : gnpl_pkg::B_READ;
            end
            gnpl_pkg::B_SQR: n_state = gnpl_pkg::B_ROOT;
            gnpl_pkg::B_ROOT: begin
                if (r_step == 5'(DW - 1)) begin
                    n_state = w_last ? gnpl_pkg::B_DONE : gnpl_pkg::B_READ;
                end
            end
            gnpl_pkg::B_DONE: begin
                o_valid = 1'b1;
                n_state = gnpl_pkg::B_IDLE;
            end
            default: n_state = gnpl_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        o_result.found            = r_any && (r_best < i_qdist);
        o_result.nearest_label    = o_result.found ? r_best_lab : '0;
        o_result.nearest_distance = r_best;
    end

    assign o_count = r_count;

endmodule
`default_nettype wire

FILE: rtl/grid_nearest_point_lookup_core.sv
// Nearest stored point lookup over a linear store of up to MAX_POINTS points.
// Each transfer holds busy while the front grid divider runs, and longer while
// the two-entry queue is full. A query then reads every stored point in turn
// and squares and takes the bit-serial square root for each point in the same
// cell or the cell one lower in each coordinate; its time is set by the single
// store read port and the bit-serial root. The result is shown for one cycle
// with o_valid; the receiver cannot stall it.
`default_nettype none
module grid_nearest_point_lookup_core #(
    parameter int unsigned MAX_POINTS = 4096
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire gnpl_pkg::t_in_item            i_item,
    output logic                               o_valid,
    output gnpl_pkg::t_out_item                o_result,
    input  wire logic                          i_cfg_we,
    input  wire logic [gnpl_pkg::IDX_W-1:0]    i_cfg_index,
    input  wire logic [gnpl_pkg::CFG_W-1:0]    i_cfg_data
);

    localparam int unsigned PTR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);

    logic [gnpl_pkg::GRID_W-1:0] r_grid;
    logic [gnpl_pkg::DIST_W-1:0] r_qdist;
    logic           w_push, w_pop, w_full, w_empty;
    gnpl_pkg::t_job w_job_in, w_job_out;
    logic [CNT_W-1:0] w_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid  <= gnpl_pkg::GRID_W'(1000);
            r_qdist <= gnpl_pkg::DIST_W'(100);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                gnpl_pkg::REG_GRID_SIZE:      r_grid  <= i_cfg_data[gnpl_pkg::GRID_W-1:0];
                gnpl_pkg::REG_QUERY_DISTANCE: r_qdist <= i_cfg_data;
                default: ;
            endcase
        end
    end

    gnpl_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_item(i_item),
        .i_grid(r_grid), .i_q_full(w_full), .o_busy(busy), .o_push(w_push),
        .o_job(w_job_in)
    );

    gnpl_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_push), .i_job(w_job_in),
        .i_pop(w_pop), .o_full(w_full), .o_empty(w_empty), .o_job(w_job_out)
    );

    gnpl_back #(.MAX_POINTS(MAX_POINTS), .PTR_W(PTR_W), .CNT_W(CNT_W)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(w_empty), .i_job(w_job_out),
        .i_qdist(r_qdist), .o_pop(w_pop), .o_valid(o_valid), .o_result(o_result),
        .o_count(w_count)
    );

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= CNT_W'(MAX_POINTS)) else $error("point count beyond store size");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |-> !w_push) else $error("push into a full queue");
    a_label_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.found) |-> (o_result.nearest_label == '0))
        else $error("label set without a match");

endmodule
`default_nettype wire
